>>> rtl/fading_life_automaton_macros.svh
`ifndef FADING_LIFE_AUTOMATON_MACROS_SVH
`define FADING_LIFE_AUTOMATON_MACROS_SVH
// implication check: label, clock, reset, antecedent, consequent, message
`define FLA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication check
`define FLA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/fla_pkg.sv
`timescale 1ns / 1ps
package fla_pkg;
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FADE   = 2'd2
   } csr_index_type;

   localparam logic [7:0] ALIVE_VALUE = 8'd255;
   localparam logic [7:0] RESET_WIDTH = 8'd100;
   localparam logic [7:0] RESET_HEIGHT = 8'd75;
   localparam logic [7:0] RESET_FADE = 8'd16;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT = 4'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] cell_x;
      logic [6:0] cell_y;
      logic [7:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [6:0] out_x;
      logic [6:0] out_y;
      logic [7:0] out_value;
      logic       generation_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_NEIGH,
      ST_CALC,
      ST_OUT
   } state_type;
endpackage

>>> rtl/fla_front.sv
`timescale 1ns / 1ps
// classifies items, drops unused opcodes, two-entry queue to the back end
module fla_front import fla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    q_valid,
   input  logic    q_pop,
   output req_type q_data
);
   req_type     q_mem_ff [2];
   req_type     q_mem_in [2];
   logic [1:0]  q_cnt_ff, q_cnt_in;
   logic        push;

   assign req_stall = (q_cnt_ff == 2'd2);
   assign push = req_valid && !req_stall && (req_data.opcode != OP_NONE);
   assign q_valid = (q_cnt_ff != 2'd0);
   assign q_data = q_mem_ff[0];

   always_comb begin
      q_mem_in = q_mem_ff;
      q_cnt_in = q_cnt_ff;
      if (q_pop && q_valid) begin
         q_mem_in[0] = q_mem_ff[1];
         q_cnt_in = q_cnt_in - 2'd1;
      end
      if (push) begin
         q_mem_in[q_cnt_in[0]] = req_data;
         q_cnt_in = q_cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_mem_ff <= q_mem_in;
      if (reset) begin
         q_cnt_ff <= 2'd0;
      end else begin
         q_cnt_ff <= q_cnt_in;
      end
   end
endmodule

>>> rtl/fla_back.sv
`timescale 1ns / 1ps
// executes items against the cell memory; one read port, 9 reads per advance
module fla_back import fla_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_pop,
   input  req_type q_data,
   input  logic [7:0] grid_width,
   input  logic [7:0] grid_height,
   input  logic [7:0] fade_step,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = 1 + YW + XW;
   localparam int DW = (XW > YW ? XW : YW) + 1;

   logic [7:0] mem [2**AW];

   state_type     st_ff, st_in;
   logic          plane_ff, plane_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [3:0]    idx_ff, idx_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [7:0]    cur_ff, cur_in;
   logic          rd_ok_ff, rd_ok_in;
   rsp_type       out_ff, out_in;
   logic          ov_ff, ov_in;
   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic [7:0]    wdata;
   logic [7:0]    rdata_ff;
   logic [DW-1:0] w_eff, h_eff;
   logic [XW-1:0] sx, nx;
   logic [YW-1:0] sy, ny;
   logic [DW:0]   tx, ty;
   logic [3:0]    nidx;
   logic [1:0]    dx, dy;
   logic [7:0]    nv;
   logic          in_grid;

   assign in_grid = (32'(q_data.cell_x) < MAX_WIDTH) && (32'(q_data.cell_y) < MAX_HEIGHT);

   always_comb begin
      if (grid_width < 8'd3) w_eff = DW'(3);
      else if (32'(grid_width) > MAX_WIDTH) w_eff = DW'(MAX_WIDTH);
      else w_eff = DW'(grid_width);
      if (grid_height < 8'd3) h_eff = DW'(3);
      else if (32'(grid_height) > MAX_HEIGHT) h_eff = DW'(MAX_HEIGHT);
      else h_eff = DW'(grid_height);
   end

   // normalized scan position
   always_comb begin
      sx = col_ff;
      sy = row_ff;
      if (DW'(col_ff) >= w_eff) begin
         sx = '0;
         sy = row_ff + YW'(1);
         if (DW'(row_ff) + DW'(1) >= h_eff) sy = '0;
      end else if (DW'(row_ff) >= h_eff) begin
         sy = '0;
      end
   end

   // neighbor address over the 3x3 ring; data for idx_ff arrives in ST_NEIGH
   always_comb begin
      nidx = (st_ff == ST_NEIGH) ? idx_ff + 4'd1 : 4'd0;
      case (nidx)
         4'd0: begin dx = 2'd0; dy = 2'd0; end
         4'd1: begin dx = 2'd1; dy = 2'd0; end
         4'd2: begin dx = 2'd2; dy = 2'd0; end
         4'd3: begin dx = 2'd0; dy = 2'd1; end
         4'd4: begin dx = 2'd2; dy = 2'd1; end
         4'd5: begin dx = 2'd0; dy = 2'd2; end
         4'd6: begin dx = 2'd1; dy = 2'd2; end
         default: begin dx = 2'd2; dy = 2'd2; end
      endcase
      tx = (DW+1)'(col_ff) + (DW+1)'(dx);
      ty = (DW+1)'(row_ff) + (DW+1)'(dy);
      if (tx == '0) nx = XW'(w_eff - DW'(1));
      else if (tx - (DW+1)'(1) >= (DW+1)'(w_eff)) nx = '0;
      else nx = XW'(tx - (DW+1)'(1));
      if (ty == '0) ny = YW'(h_eff - DW'(1));
      else if (ty - (DW+1)'(1) >= (DW+1)'(h_eff)) ny = '0;
      else ny = YW'(ty - (DW+1)'(1));
   end

   always_comb begin
      if (cur_ff != ALIVE_VALUE && cnt_ff == BIRTH_COUNT) nv = ALIVE_VALUE;
      else if (cur_ff == ALIVE_VALUE && (cnt_ff == KEEP_COUNT || cnt_ff == BIRTH_COUNT))
         nv = cur_ff;
      else if (cur_ff > fade_step) nv = cur_ff - fade_step;
      else nv = 8'd0;
   end

   always_comb begin
      st_in = st_ff;
      plane_in = plane_ff;
      col_in = col_ff;
      row_in = row_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      rd_ok_in = rd_ok_ff;
      out_in = out_ff;
      ov_in = ov_ff && rsp_stall;
      q_pop = 1'b0;
      we = 1'b0;
      waddr = {plane_ff, YW'(q_data.cell_y), XW'(q_data.cell_x)};
      wdata = q_data.cell_value;
      raddr = {plane_ff, YW'(q_data.cell_y), XW'(q_data.cell_x)};
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_data.opcode)
                  OP_WRITE: begin
                     q_pop = 1'b1;
                     we = in_grid;
                  end
                  OP_READ: begin
                     if (!ov_in) begin
                        q_pop = 1'b1;
                        rd_ok_in = in_grid;
                        out_in.out_x = q_data.cell_x;
                        out_in.out_y = q_data.cell_y;
                        out_in.generation_done = 1'b0;
                        st_in = ST_OUT;
                     end
                  end
                  OP_ADVANCE: begin
                     q_pop = 1'b1;
                     col_in = sx;
                     row_in = sy;
                     raddr = {plane_ff, sy, sx};
                     idx_in = '0;
                     cnt_in = '0;
                     st_in = ST_CENTER;
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_CENTER: begin
            cur_in = rdata_ff;
            raddr = {plane_ff, ny, nx};
            st_in = ST_NEIGH;
         end
         ST_NEIGH: begin
            if (rdata_ff == ALIVE_VALUE) cnt_in = cnt_ff + 4'd1;
            raddr = {plane_ff, ny, nx};
            if (idx_ff == 4'd7) st_in = ST_CALC;
            else idx_in = idx_ff + 4'd1;
         end
         ST_CALC: begin
            if (!ov_in) begin
               ov_in = 1'b1;
               out_in.out_x = 7'(col_ff);
               out_in.out_y = 7'(row_ff);
               out_in.out_value = nv;
               out_in.generation_done = 1'b0;
               we = 1'b1;
               waddr = {~plane_ff, row_ff, col_ff};
               wdata = nv;
               if (DW'(col_ff) + DW'(1) >= w_eff) begin
                  col_in = '0;
                  if (DW'(row_ff) + DW'(1) >= h_eff) begin
                     row_in = '0;
                     plane_in = ~plane_ff;
                     out_in.generation_done = 1'b1;
                  end else begin
                     row_in = row_ff + YW'(1);
                  end
               end else begin
                  col_in = col_ff + XW'(1);
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            // ST_OUT: read data arrives, output slot was freed in ST_IDLE
            ov_in = 1'b1;
            out_in.out_value = rd_ok_ff ? rdata_ff : 8'd0;
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      cur_ff <= cur_in;
      rd_ok_ff <= rd_ok_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         plane_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         idx_ff <= '0;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         plane_ff <= plane_in;
         col_ff <= col_in;
         row_ff <= row_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;
endmodule

>>> rtl/fading_life_automaton.sv
`timescale 1ns / 1ps
// One memory read port: an advance does the center read plus 8 neighbor reads,
// then the compute step; a read waits for a free output slot before it starts.
// The back end takes a new item only when idle, one write per cycle while idle;
// a 2-entry queue lets the input keep accepting while the back end works.
// Reset: synchronous; registers to 100/75/16, plane 0, scan at origin.
// Cell memory is not cleared.
module fading_life_automaton import fla_pkg::*; #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   logic [7:0] width_ff, height_ff, fade_ff;
   logic       q_valid, q_pop;
   req_type    q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         fade_ff <= RESET_FADE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_FADE:   fade_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fla_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   fla_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .grid_width(width_ff), .grid_height(height_ff), .fade_step(fade_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

>>> rtl/fla_checker.sv
`timescale 1ns / 1ps
`include "fading_life_automaton_macros.svh"
module fla_checker import fla_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   `FLA_ASSERT_NXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "held result changed")
   `FLA_ASSERT_IMP(a_rsp_known, clock, reset,
      rsp_valid, !$isunknown(rsp_data), "result carries unknown bits")
   `FLA_ASSERT_IMP(a_done_coord, clock, reset, rsp_valid && rsp_data.generation_done,
      rsp_data.out_x >= 7'd2 && rsp_data.out_y >= 7'd2, "generation end below minimum grid")
   `FLA_ASSERT_IMP(a_reset_quiet, clock, reset,
      $fell(reset), !req_stall && !rsp_valid, "busy right after reset")
endmodule

bind fading_life_automaton fla_checker u_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import fla_pkg::*;

   localparam int SIDE = 128;
   localparam int PLANE = SIDE * SIDE;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 40;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   fading_life_automaton dut (.*);

   // life state as this bench sees it
   logic [7:0] cells [2*PLANE];
   bit         known [2*PLANE];
   bit         cur_plane;
   int         scan_col, scan_row;
   logic [7:0] width_reg = RESET_WIDTH, height_reg = RESET_HEIGHT, fade_reg = RESET_FADE;

   rsp_type pending_rsp [$];
   int  errors = 0, checked = 0, generations = 0, sent = 0;
   bit  quiet = 0, hold_start = 0;
   int  hold_left = 0;
   longint cycles = 0;

   initial forever #4 clock = ~clock;

   function automatic int clamp_dim(logic [7:0] v);
      if (v < 3) return 3;
      if (v > SIDE) return SIDE;
      return v;
   endfunction

   function automatic int cell_addr(bit p, int x, int y);
      return p * PLANE + y * SIDE + x;
   endfunction

   function automatic void predict_cell(req_type r);
      int w, h, cx, cy, n, nx, ny;
      logic [7:0] cur, nv;
      rsp_type e;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      case (r.opcode)
         OP_WRITE: begin
            cells[cell_addr(cur_plane, r.cell_x, r.cell_y)] = r.cell_value;
            known[cell_addr(cur_plane, r.cell_x, r.cell_y)] = 1;
         end
         OP_READ: begin
            e.out_x = r.cell_x;
            e.out_y = r.cell_y;
            e.out_value = cells[cell_addr(cur_plane, r.cell_x, r.cell_y)];
            e.generation_done = 0;
            pending_rsp.push_back(e);
         end
         OP_ADVANCE: begin
            if (scan_col >= w) begin
               scan_col = 0;
               scan_row++;
            end
            if (scan_row >= h) scan_row = 0;
            cx = scan_col;
            cy = scan_row;
            cur = cells[cell_addr(cur_plane, cx, cy)];
            n = 0;
            for (int dy = 0; dy < 3; dy++)
               for (int dx = 0; dx < 3; dx++) begin
                  if (dx == 1 && dy == 1) continue;
                  nx = (cx + w + dx - 1) % w;
                  ny = (cy + h + dy - 1) % h;
                  if (cells[cell_addr(cur_plane, nx, ny)] == ALIVE_VALUE) n++;
               end
            if (cur != ALIVE_VALUE && n == BIRTH_COUNT) nv = ALIVE_VALUE;
            else if (cur == ALIVE_VALUE && (n == KEEP_COUNT || n == BIRTH_COUNT)) nv = cur;
            else nv = (cur > fade_reg) ? cur - fade_reg : 8'd0;
            cells[cell_addr(!cur_plane, cx, cy)] = nv;
            known[cell_addr(!cur_plane, cx, cy)] = 1;
            e.out_x = 7'(cx);
            e.out_y = 7'(cy);
            e.out_value = nv;
            e.generation_done = 0;
            if (cx + 1 >= w) begin
               scan_col = 0;
               if (cy + 1 >= h) begin
                  scan_row = 0;
                  cur_plane = !cur_plane;
                  e.generation_done = 1;
                  generations++;
               end else begin
                  scan_row = cy + 1;
               end
            end else begin
               scan_col = cx + 1;
            end
            pending_rsp.push_back(e);
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(req_type r);
      predict_cell(r);
      sent++;
      if (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_op(op_type op, int x, int y, int v);
      req_type r;
      r.opcode = op;
      r.cell_x = 7'(x);
      r.cell_y = 7'(y);
      r.cell_value = 8'(v);
      send_item(r);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_setup(logic [7:0] w, logic [7:0] h, logic [7:0] fade);
      csr_we <= 1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= CSR_FADE;
      csr_wdata <= fade;
      @(posedge clock);
      csr_we <= 0;
      width_reg = w;
      height_reg = h;
      fade_reg = fade;
   endtask

   function automatic logic [7:0] rand_cell();
      return ($urandom_range(1) == 0) ? ALIVE_VALUE : 8'($urandom);
   endfunction

   // load any unwritten cell that the next advance will look at
   task automatic cover_next();
      int w, h, cx, cy, nx, ny;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      cx = scan_col;
      cy = scan_row;
      if (cx >= w) begin
         cx = 0;
         cy++;
      end
      if (cy >= h) cy = 0;
      for (int dy = 0; dy < 3; dy++)
         for (int dx = 0; dx < 3; dx++) begin
            nx = (cx + w + dx - 1) % w;
            ny = (cy + h + dy - 1) % h;
            if (!known[cell_addr(cur_plane, nx, ny)]) send_op(OP_WRITE, nx, ny, rand_cell());
         end
   endtask

   task automatic send_advance();
      cover_next();
      send_op(OP_ADVANCE, $urandom, $urandom, $urandom);
   endtask

   task automatic send_read();
      int x, y;
      for (int t = 0; t < 8; t++) begin
         x = $urandom_range(SIDE - 1);
         y = $urandom_range(SIDE - 1);
         if (known[cell_addr(cur_plane, x, y)]) break;
      end
      if (!known[cell_addr(cur_plane, x, y)]) send_op(OP_WRITE, x, y, rand_cell());
      send_op(OP_READ, x, y, $urandom);
   endtask

   task automatic test_directed();
      csr_setup(8'd2, 8'd1, 8'd0);
      send_op(OP_WRITE, 127, 127, 0);
      send_op(OP_WRITE, 0, 0, 255);
      send_op(OP_WRITE, 127, 0, 128);
      send_op(OP_WRITE, 0, 127, 1);
      send_op(OP_READ, 127, 127, 255);
      send_op(OP_READ, 0, 0, 0);
      send_op(OP_READ, 127, 0, 0);
      send_op(OP_READ, 0, 127, 0);
      send_op(OP_NONE, 127, 127, 255);
      send_op(OP_NONE, 0, 0, 0);
      // blinker-ish pattern on the smallest torus
      send_op(OP_WRITE, 1, 0, 255);
      send_op(OP_WRITE, 2, 0, 0);
      for (int y = 1; y < 3; y++)
         for (int x = 0; x < 3; x++) send_op(OP_WRITE, x, y, (x == 1) ? 255 : 200);
      for (int i = 0; i < 9; i++) send_advance();
      send_op(OP_READ, 1, 1, 0);
      wait_idle();
   endtask

   task automatic test_random_phase(logic [7:0] w, logic [7:0] h, logic [7:0] fade, int n,
                                    bit with_hold, bit with_pause);
      int pick;
      csr_setup(w, h, fade);
      for (int i = 0; i < n; i++) begin
         if (with_hold && i == n / 3) hold_start = 1;
         if (with_pause && i == n / 2) wait_idle();
         pick = $urandom_range(99);
         if (pick < 60) send_advance();
         else if (pick < 80)
            send_op(OP_WRITE, $urandom, $urandom, ($urandom_range(2) == 0) ? 0 : rand_cell());
         else if (pick < 95) send_read();
         else send_op(OP_NONE, $urandom, $urandom, $urandom);
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_rsp.size());
         $display("FAILURE");
         $finish;
      end
      if (hold_start) begin
         hold_left = 400;
         hold_start = 0;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result x=%0d y=%0d value=%0d", rsp_data.out_x,
                   rsp_data.out_y, rsp_data.out_value);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            checked++;
            if (rsp_data.out_x !== e.out_x) begin
               $error("out_x expected %0d actual %0d", e.out_x, rsp_data.out_x);
               errors++;
            end
            if (rsp_data.out_y !== e.out_y) begin
               $error("out_y expected %0d actual %0d", e.out_y, rsp_data.out_y);
               errors++;
            end
            if (rsp_data.out_value !== e.out_value) begin
               $error("out_value expected %0d actual %0d", e.out_value, rsp_data.out_value);
               errors++;
            end
            if (rsp_data.generation_done !== e.generation_done) begin
               $error("generation_done expected %0d actual %0d", e.generation_done,
                      rsp_data.generation_done);
               errors++;
            end
         end
      end
   end

   initial begin
      cur_plane = 0;
      scan_col = 0;
      scan_row = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random_phase(8'd5, 8'd4, 8'd16, 100, 1, 0);
      test_random_phase(8'd200, 8'd3, 8'd255, 60, 0, 1);
      quiet = 1;
      test_random_phase(8'd3, 8'd255, 8'd0, 80, 0, 0);
      quiet = 0;
      test_random_phase(8'd0, 8'd0, 8'd1, 60, 0, 0);
      test_random_phase(8'd7, 8'd6, 8'd100, 80, 0, 0);
      // shrink mid-generation, scan position falls outside the grid
      test_random_phase(8'd4, 8'd3, 8'd50, 70, 1, 0);
      $display("%0d items sent, %0d results checked, %0d generations completed",
               sent, checked, generations);
      $display("grid sizes from 3x3 to 128 wide and 128 tall, fade steps 0 to 255");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
